// ===== design/hccm_pkg.sv =====
`default_nettype none

package hccm_pkg;

  // Fixed field widths
  localparam int KIND_W    = 1;
  localparam int SLOT_IN_W = 2;
  localparam int VERTEX_W  = 12;
  localparam int PART_W    = 6;
  localparam int WEIGHT_W  = 16;
  localparam int TERM_W    = 22;
  localparam int COUNT_W   = 7;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 2;

  // Table geometry: one slot spans the whole vertex field
  localparam int MAX_VERTICES = 4096;

  // Parameter defaults
  localparam int MAX_PARTS_DEF = 64;
  localparam int NUM_SLOTS_DEF = 4;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
  localparam logic [KIND_W-1:0] KIND_PIN  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_SELECT = 1'b1;

  // Metric modes
  localparam logic MODE_CONNECTIVITY = 1'b0;
  localparam logic MODE_EXT_DEGREE   = 1'b1;

  // Pin beat waiting on its table read
  typedef struct packed {
    logic                valid;
    logic [WEIGHT_W-1:0] weight;
    logic                last_pin;
    logic                last_edge;
  } hccm_pin_t;

  // Closed hyperedge headed for scoring
  typedef struct packed {
    logic                valid;
    logic [COUNT_W-1:0]  count;
    logic [WEIGHT_W-1:0] weight;
    logic                last_edge;
  } hccm_edge_t;

endpackage

`default_nettype wire

// ===== design/hyperedge_connectivity_cut_meter.sv =====
// A last pin's result passes the table read, span update, multiply and output
// registers in that order before it appears on the outputs.
// Throughput: one item per cycle while no output beat waits; load and pin beats interleave freely.
// The whole pipeline (table read, span update, multiply, accumulate) advances
// together and holds while an output beat waits, so in_ready follows out_ready.
// Reset (rst, synchronous) clears configuration, mask, count, total and valids;
// the part table is not cleared and its unwritten entries read as anything.
`default_nettype none

module hyperedge_connectivity_cut_meter #(
  parameter int MAX_PARTS = hccm_pkg::MAX_PARTS_DEF,
  parameter int NUM_SLOTS = hccm_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [hccm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hccm_pkg::CFG_W-1:0]          cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [hccm_pkg::KIND_W-1:0]         kind,
  input  wire logic [hccm_pkg::SLOT_IN_W-1:0]      slot,
  input  wire logic [hccm_pkg::VERTEX_W-1:0]       vertex,
  input  wire logic [hccm_pkg::PART_W-1:0]         part,
  input  wire logic [hccm_pkg::WEIGHT_W-1:0]       edge_weight,
  input  wire logic                                last_pin,
  input  wire logic                                last_edge,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [hccm_pkg::TERM_W-1:0]              edge_term,
  output logic [hccm_pkg::COUNT_W-1:0]             parts_spanned,
  output logic [hccm_pkg::TOTAL_W-1:0]             running_total,
  output logic                                     is_final
);

  // Table holds NUM_SLOTS slots, each addressed by the full vertex field
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int DEPTH  = NUM_SLOTS * hccm_pkg::MAX_VERTICES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FULL_W = SLOT_W + hccm_pkg::VERTEX_W;

  // Fold a slot code into range; a 2-bit code stays below twice NUM_SLOTS
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [hccm_pkg::SLOT_IN_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (NUM_SLOTS == 1) begin
      r = '0;
    end else if (32'(s) >= NUM_SLOTS) begin
      r = SLOT_W'(32'(s) - NUM_SLOTS);
    end else begin
      r = SLOT_W'(s);
    end
    return r;
  endfunction

  logic                              metric_mode;
  logic [hccm_pkg::CFG_W-1:0]        partition_select;

  logic                              adv;
  logic                              accept;
  logic                              load_we;
  logic [FULL_W-1:0]                 wr_full;
  logic [FULL_W-1:0]                 rd_full;
  logic [hccm_pkg::PART_W-1:0]       rd_part;

  hccm_pkg::hccm_pin_t               pin_q;
  hccm_pkg::hccm_edge_t              edge_q;

  // Configuration writes land directly; index decode covers the whole list
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode      <= hccm_pkg::MODE_CONNECTIVITY;
      partition_select <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hccm_pkg::REG_METRIC_MODE:      metric_mode      <= cfg_data[0];
        hccm_pkg::REG_PARTITION_SELECT: partition_select <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance every stage only when the output register is free or draining
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;
  assign load_we  = accept && (kind == hccm_pkg::KIND_LOAD);

  // Writes of one beat are seen by the read of any later beat
  assign wr_full = {wrap_slot(slot), vertex};
  assign rd_full = {wrap_slot(partition_select), vertex};

  hccm_part_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_part_mem (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (wr_full[ADDR_W-1:0]),
    .wr_data (part),
    .rd_en   (adv),
    .rd_addr (rd_full[ADDR_W-1:0]),
    .rd_data (rd_part)
  );

  // Pin beat rides alongside its table read
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_q <= '0;
    end else if (adv) begin
      pin_q.valid     <= accept && (kind == hccm_pkg::KIND_PIN);
      pin_q.weight    <= edge_weight;
      pin_q.last_pin  <= last_pin;
      pin_q.last_edge <= last_edge;
    end
  end

  hccm_span_unit #(
    .MAX_PARTS (MAX_PARTS)
  ) u_span (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .pin     (pin_q),
    .rd_part (rd_part),
    .edge_q  (edge_q)
  );

  hccm_score_unit u_score (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .metric_mode   (metric_mode),
    .edge_in       (edge_q),
    .out_valid     (out_valid),
    .edge_term     (edge_term),
    .parts_spanned (parts_spanned),
    .running_total (running_total),
    .is_final      (is_final)
  );

endmodule

`default_nettype wire

// ===== design/hccm_part_mem.sv =====
`default_nettype none

module hccm_part_mem #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [hccm_pkg::PART_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [hccm_pkg::PART_W-1:0] rd_data
);

  logic [hccm_pkg::PART_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/hccm_span_unit.sv =====
`default_nettype none

module hccm_span_unit #(
  parameter int MAX_PARTS = hccm_pkg::MAX_PARTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire hccm_pkg::hccm_pin_t         pin,
  input  wire logic [hccm_pkg::PART_W-1:0] rd_part,
  output hccm_pkg::hccm_edge_t             edge_q
);

  localparam int PI_W  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int NCODE = 1 << hccm_pkg::PART_W;

  // Part code folded into the part range, built at elaboration
  function automatic logic [NCODE*hccm_pkg::PART_W-1:0] build_fold();
    logic [NCODE*hccm_pkg::PART_W-1:0] r;
    r = '0;
    for (int i = 0; i < NCODE; i++) begin
      r[i*hccm_pkg::PART_W +: hccm_pkg::PART_W] = hccm_pkg::PART_W'(i % MAX_PARTS);
    end
    return r;
  endfunction

  localparam logic [NCODE*hccm_pkg::PART_W-1:0] FOLD = build_fold();

  logic [MAX_PARTS-1:0]            mask;
  logic [MAX_PARTS-1:0]            mask_next;
  logic [hccm_pkg::COUNT_W-1:0]    count;
  logic [hccm_pkg::COUNT_W-1:0]    count_next;
  logic [hccm_pkg::PART_W-1:0]     folded;
  logic [PI_W-1:0]                 pidx;

  always_comb begin
    folded     = FOLD[rd_part*hccm_pkg::PART_W +: hccm_pkg::PART_W];
    pidx       = folded[PI_W-1:0];
    mask_next  = mask;
    count_next = count;
    if (!mask[pidx]) begin
      mask_next[pidx] = 1'b1;
      count_next      = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask   <= '0;
      count  <= '0;
      edge_q <= '0;
    end else if (adv) begin
      edge_q.valid     <= pin.valid && pin.last_pin;
      edge_q.count     <= count_next;
      edge_q.weight    <= pin.weight;
      edge_q.last_edge <= pin.last_edge;
      if (pin.valid) begin
        if (pin.last_pin) begin
          mask  <= '0;
          count <= '0;
        end else begin
          mask  <= mask_next;
          count <= count_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hccm_score_unit.sv =====
`default_nettype none

module hccm_score_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         metric_mode,
  input  wire hccm_pkg::hccm_edge_t         edge_in,
  output logic                              out_valid,
  output logic [hccm_pkg::TERM_W-1:0]       edge_term,
  output logic [hccm_pkg::COUNT_W-1:0]      parts_spanned,
  output logic [hccm_pkg::TOTAL_W-1:0]      running_total,
  output logic                              is_final
);

  localparam int PROD_W = hccm_pkg::COUNT_W + hccm_pkg::WEIGHT_W;

  logic [hccm_pkg::COUNT_W-1:0] mult;
  logic [PROD_W-1:0]            prod;

  logic                         a_valid;
  logic [hccm_pkg::TERM_W-1:0]  a_term;
  logic [hccm_pkg::COUNT_W-1:0] a_count;
  logic                         a_last_edge;

  logic [hccm_pkg::TOTAL_W-1:0] total;
  logic [hccm_pkg::TOTAL_W:0]   sum;
  logic [hccm_pkg::TOTAL_W-1:0] sat;

  always_comb begin
    mult = '0;
    unique case (metric_mode)
      hccm_pkg::MODE_CONNECTIVITY: begin
        if (edge_in.count != '0) mult = edge_in.count - 1'b1;
      end
      hccm_pkg::MODE_EXT_DEGREE: begin
        if (edge_in.count > hccm_pkg::COUNT_W'(1)) mult = edge_in.count;
      end
      default: mult = '0;
    endcase
    prod = PROD_W'(mult) * PROD_W'(edge_in.weight);
  end

  always_comb begin
    sum = {1'b0, total} + (hccm_pkg::TOTAL_W + 1)'(a_term);
    sat = sum[hccm_pkg::TOTAL_W] ? '1 : sum[hccm_pkg::TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      total     <= '0;
    end else if (adv) begin
      a_valid   <= edge_in.valid;
      out_valid <= a_valid;
      if (a_valid) begin
        // Restart the total after the final hyperedge
        total <= a_last_edge ? '0 : sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_term        <= prod[hccm_pkg::TERM_W-1:0];
      a_count       <= edge_in.count;
      a_last_edge   <= edge_in.last_edge;
      edge_term     <= a_term;
      parts_spanned <= a_count;
      running_total <= sat;
      is_final      <= a_last_edge;
    end
  end

endmodule

`default_nettype wire

// ===== design/hccm_checker.sv =====
`default_nettype none

module hccm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [hccm_pkg::TERM_W-1:0]     edge_term,
  input wire logic [hccm_pkg::COUNT_W-1:0]    parts_spanned,
  input wire logic [hccm_pkg::TOTAL_W-1:0]    running_total,
  input wire logic                            is_final
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(edge_term) &&
      $stable(parts_spanned) && $stable(running_total) && $stable(is_final)))
    else $error("output beat changed while stalled");

  // A waiting result blocks intake
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // Total always includes this edge's term
  a_total_cover: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(edge_term) <= running_total))
    else $error("running total below edge term");

  // A single-part hyperedge costs nothing
  a_one_part: assert property (@(posedge clk) disable iff (rst)
    (out_valid && parts_spanned == hccm_pkg::COUNT_W'(1)) |-> (edge_term == '0))
    else $error("nonzero term for uncut hyperedge");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind hyperedge_connectivity_cut_meter hccm_checker u_hccm_checker (.*);

`default_nettype wire

// ===== dv/hccm_checker.sv =====
`timescale 1ns / 100ps

module hccm_scoreboard (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [hccm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hccm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [hccm_pkg::KIND_W-1:0]    kind,
  input  wire logic [hccm_pkg::SLOT_IN_W-1:0] slot,
  input  wire logic [hccm_pkg::VERTEX_W-1:0]  vertex,
  input  wire logic [hccm_pkg::PART_W-1:0]    part,
  input  wire logic [hccm_pkg::WEIGHT_W-1:0]  edge_weight,
  input  wire logic                           last_pin,
  input  wire logic                           last_edge,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [hccm_pkg::TERM_W-1:0]    edge_term,
  input  wire logic [hccm_pkg::COUNT_W-1:0]   parts_spanned,
  input  wire logic [hccm_pkg::TOTAL_W-1:0]   running_total,
  input  wire logic                           is_final,
  output int unsigned                         mismatches,
  output int unsigned                         scores_due
);
  import hccm_pkg::*;

  localparam int TABLE_DEPTH = NUM_SLOTS_DEF * MAX_VERTICES;

  typedef struct packed {
    logic [TERM_W-1:0]  term;
    logic [COUNT_W-1:0] parts;
    logic [TOTAL_W-1:0] total;
    logic               closes_run;
  } edge_score_t;

  // Shadow of the block: part table, open-edge mask and count, cut total, registers
  logic [PART_W-1:0]        part_map [0:TABLE_DEPTH-1];
  logic [MAX_PARTS_DEF-1:0] seen_parts;
  logic [COUNT_W-1:0]       seen_count;
  logic [TOTAL_W-1:0]       cut_total;
  logic                     mode_q;
  logic [CFG_W-1:0]         psel_q;
  edge_score_t              pending_scores [$];

  edge_score_t              oldest;
  edge_score_t              fresh;
  int unsigned              hit_part;
  logic [63:0]              span64;
  logic [63:0]              wt64;
  logic [63:0]              term64;
  logic [63:0]              sum64;

  function automatic int map_index(input logic [SLOT_IN_W-1:0] s,
                                   input logic [VERTEX_W-1:0] v);
    return (int'(s) % NUM_SLOTS_DEF) * MAX_VERTICES + (int'(v) % MAX_VERTICES);
  endfunction

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      seen_parts = '0;
      seen_count = '0;
      cut_total  = '0;
      mode_q     = MODE_CONNECTIVITY;
      psel_q     = '0;
      pending_scores.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_METRIC_MODE)
          mode_q = cfg_data[0];
        else if (cfg_index == REG_PARTITION_SELECT)
          psel_q = cfg_data;
      end

      // Compare the outgoing beat against the oldest scored edge
      if (out_valid && out_ready) begin
        if (pending_scores.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual term %0d total %0d",
                   $time, edge_term, running_total);
        end else begin
          oldest = pending_scores.pop_front();
          if (edge_term !== oldest.term)
            flag("edge_term", 32'(oldest.term), 32'(edge_term));
          if (parts_spanned !== oldest.parts)
            flag("parts_spanned", 32'(oldest.parts), 32'(parts_spanned));
          if (running_total !== oldest.total)
            flag("running_total", oldest.total, running_total);
          if (is_final !== oldest.closes_run)
            flag("is_final", 32'(oldest.closes_run), 32'(is_final));
        end
      end

      if (in_valid && in_ready) begin
        if (kind == KIND_LOAD) begin
          part_map[map_index(slot, vertex)] = part;
        end else begin
          hit_part = int'(part_map[map_index(psel_q, vertex)]) % MAX_PARTS_DEF;
          if (!seen_parts[hit_part]) begin
            seen_parts[hit_part] = 1'b1;
            seen_count = seen_count + 1'b1;
          end
          if (last_pin) begin
            span64 = {57'd0, seen_count};
            wt64   = {48'd0, edge_weight};
            if (mode_q == MODE_CONNECTIVITY)
              term64 = (span64 >= 64'd1) ? (span64 - 64'd1) * wt64 : 64'd0;
            else
              term64 = (span64 > 64'd1) ? span64 * wt64 : 64'd0;
            term64 = term64 & 64'h3F_FFFF;
            sum64  = {32'd0, cut_total} + term64;
            if (sum64 > 64'hFFFF_FFFF)
              sum64 = 64'hFFFF_FFFF;
            cut_total        = sum64[31:0];
            fresh.term       = term64[TERM_W-1:0];
            fresh.parts      = seen_count;
            fresh.total      = cut_total;
            fresh.closes_run = last_edge;
            pending_scores.push_back(fresh);
            seen_parts = '0;
            seen_count = '0;
            if (last_edge)
              cut_total = '0;
          end
        end
      end
    end
    scores_due = pending_scores.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hccm_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int WIDE_EDGES   = 2;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind = KIND_LOAD;
  logic [SLOT_IN_W-1:0] slot = '0;
  logic [VERTEX_W-1:0]  vertex = '0;
  logic [PART_W-1:0]    part = '0;
  logic [WEIGHT_W-1:0]  edge_weight = '0;
  logic                 last_pin = 1'b0;
  logic                 last_edge = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TERM_W-1:0]    edge_term;
  logic [COUNT_W-1:0]   parts_spanned;
  logic [TOTAL_W-1:0]   running_total;
  logic                 is_final;

  int unsigned          mismatches;
  int unsigned          scores_due;

  // Idle odds in percent, per side
  int unsigned          send_gap_pct = 0;
  int unsigned          recv_stall_pct = 0;

  // Long receiver hold-off: main bumps the request, the receiver serves it
  int unsigned          hold_asked = 0;
  int unsigned          hold_served = 0;
  int unsigned          hold_left = 0;
  int unsigned          cycle_count = 0;

  // Which table entries hold a part, so a pin never looks up an unwritten one
  bit                   loaded [0:NUM_SLOTS_DEF-1][0:MAX_VERTICES-1];
  logic [VERTEX_W-1:0]  pool_v [0:NUM_SLOTS_DEF-1][0:MAX_VERTICES-1];
  int unsigned          pool_n [0:NUM_SLOTS_DEF-1];
  logic [CFG_W-1:0]     cur_psel = '0;

  // Vertices seeded with one distinct part each, used for full-span edges
  logic [VERTEX_W-1:0]  wide_v [0:63];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hyperedge_connectivity_cut_meter i_dut (.*);

  hccm_scoreboard i_checker (.*);

  // Receiver: random stalls, or a long hold-off counted here on request
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted. Called and returns at a falling
  // edge; valid stays up on return, so back-to-back beats drop it only for a sender gap.
  task automatic send_beat(input logic [KIND_W-1:0] k, input logic [SLOT_IN_W-1:0] s,
                           input logic [VERTEX_W-1:0] v, input logic [PART_W-1:0] p,
                           input logic [WEIGHT_W-1:0] w, input logic lp, input logic le);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    slot        <= s;
    vertex      <= v;
    part        <= p;
    edge_weight <= w;
    last_pin    <= lp;
    last_edge   <= le;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write a vertex's part into one slot; the pin flags ride along and must be ignored
  task automatic load_vertex(input logic [SLOT_IN_W-1:0] s, input logic [VERTEX_W-1:0] v,
                             input logic [PART_W-1:0] p, input logic lp, input logic le);
    send_beat(KIND_LOAD, s, v, p, 16'($urandom_range(65535)), lp, le);
    if (!loaded[s][v]) begin
      loaded[s][v] = 1'b1;
      pool_v[s][pool_n[s]] = v;
      pool_n[s]++;
    end
  endtask

  // Pin beat; slot and part are don't-cares for a pin, so scramble them
  task automatic pin_vertex(input logic [VERTEX_W-1:0] v, input logic [WEIGHT_W-1:0] w,
                            input logic lp, input logic le);
    send_beat(KIND_PIN, 2'($urandom_range(3)), v, 6'($urandom_range(63)), w, lp, le);
  endtask

  function automatic logic [VERTEX_W-1:0] pick_vertex();
    return pool_v[cur_psel][$urandom_range(pool_n[cur_psel] - 1)];
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0)
      return '0;
    if (roll == 1)
      return '1;
    return 16'($urandom_range(65535));
  endfunction

  task automatic random_load();
    logic [SLOT_IN_W-1:0] s;
    logic [VERTEX_W-1:0]  v;
    s = 2'($urandom_range(3));
    if (pool_n[s] != 0 && $urandom_range(1) == 1)
      v = pool_v[s][$urandom_range(pool_n[s] - 1)];
    else
      v = 12'($urandom_range(4095));
    load_vertex(s, v, 6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Mostly short hyperedges with loads woven in, now and then a longer one.
  // Non-last pins sometimes carry a stray weight or last_edge, both ignored.
  task automatic random_traffic(input int count);
    int                  sent;
    int                  pins;
    int                  p;
    logic [WEIGHT_W-1:0] w;
    logic [WEIGHT_W-1:0] pin_w;
    logic                tail;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        random_load();
        sent++;
      end else begin
        pins = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(4, 1);
        w = pick_weight();
        for (p = 0; p < pins; p++) begin
          if ($urandom_range(9) == 0) begin
            random_load();
            sent++;
          end
          tail  = (p == pins - 1);
          pin_w = (!tail && $urandom_range(9) == 0) ? 16'($urandom_range(65535)) : w;
          pin_vertex(pick_vertex(), pin_w, tail,
                     tail ? ($urandom_range(9) == 0) : 1'($urandom_range(1)));
          sent++;
        end
      end
    end
  endtask

  // One edge touching all 64 parts, the first vertex hit twice
  task automatic span_all_parts(input logic [WEIGHT_W-1:0] w, input logic le);
    int unsigned first;
    int          i;
    first = $urandom_range(63);
    for (i = 0; i <= 64; i++)
      pin_vertex(wide_v[(first + i) % 64], w, i == 64, (i == 64) ? le : 1'b0);
  endtask

  // Drop valid and wait out every pending score plus the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (scores_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Reconfigure while idle, seed the selected slot, then stream traffic
  task automatic run_phase(input logic [CFG_W-1:0] mode_data, input logic [CFG_W-1:0] psel,
                           input int seed_n, input int wide_n, input bit long_hold,
                           input int random_n);
    logic [VERTEX_W-1:0] base;
    int                  i;
    settle();
    cfg_write(REG_METRIC_MODE, mode_data);
    cfg_write(REG_PARTITION_SELECT, psel);
    cur_psel = psel;
    // Stride 64 keeps the seeded vertices distinct
    base = 12'($urandom_range(4095));
    for (i = 0; i < seed_n; i++) begin
      wide_v[i] = base + 12'(i * 64);
      load_vertex(psel, wide_v[i], (seed_n == 64) ? 6'(i) : 6'($urandom_range(63)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    // Full-span edges at top weight
    for (i = 0; i < wide_n; i++)
      span_all_parts(16'hFFFF, (wide_n > 1) ? (i == wide_n - 1) : 1'($urandom_range(1)));
    if (long_hold)
      hold_asked++;
    random_traffic(random_n);
  endtask

  initial begin
    send_gap_pct   = 35;
    recv_stall_pct = 67;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, flags on loads, stray last_edge, read right after write
    load_vertex(2'd0, 12'd0, 6'd0, 1'b1, 1'b1);
    load_vertex(2'd0, 12'hFFF, 6'd63, 1'b1, 1'b0);
    load_vertex(2'd3, 12'hFFF, 6'd63, 1'b0, 1'b1);
    load_vertex(2'd1, 12'd0, 6'd21, 1'b0, 1'b0);
    load_vertex(2'd2, 12'hAAA, 6'd42, 1'b0, 1'b0);
    load_vertex(2'd0, 12'h555, 6'd42, 1'b0, 1'b0);
    pin_vertex(12'd0, 16'hFFFF, 1'b1, 1'b0);      // single part scores nothing
    pin_vertex(12'd0, 16'd0, 1'b0, 1'b1);         // last_edge on an inner pin
    pin_vertex(12'hFFF, 16'd123, 1'b0, 1'b1);
    pin_vertex(12'h555, 16'hFFFF, 1'b1, 1'b0);    // three parts at top weight
    load_vertex(2'd0, 12'd7, 6'd63, 1'b0, 1'b0);
    pin_vertex(12'd7, 16'hFFFF, 1'b0, 1'b0);      // lookup right behind its write
    pin_vertex(12'hFFF, 16'd0, 1'b1, 1'b0);       // zero weight
    load_vertex(2'd0, 12'd7, 6'd5, 1'b1, 1'b1);
    pin_vertex(12'd7, 16'hFFFF, 1'b1, 1'b1);      // close the run, total clears
    pin_vertex(12'd0, 16'd1, 1'b1, 1'b0);

    // Sender idles 35%, receiver 67%
    run_phase(2'd1, 2'd3, 16, 0, 1'b0, 120);
    run_phase(2'd0, 2'd1, 64, 1, 1'b0, 120);

    // Swap the odds
    send_gap_pct   = 67;
    recv_stall_pct = 35;
    run_phase(2'd1, 2'd2, 16, 0, 1'b0, 120);
    run_phase(2'd0, 2'd3, 16, 0, 1'b0, 120);

    // No idling; upper mode bit must be masked off; long hold-off fills the pipe
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(2'b10, 2'd0, 16, 0, 1'b1, 160);
    run_phase(2'd1, 2'd1, 64, WIDE_EDGES, 1'b0, 120);

    settle();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
